// ----- hw/rtl/canonical_huffman_stream_decoder_unit_macros.svh -----
// Assertion macros for the canonical Huffman stream decoder.
// Used by chsd_core and the top level; no other dependencies.
`ifndef CANONICAL_HUFFMAN_STREAM_DECODER_UNIT_MACROS_SVH
`define CANONICAL_HUFFMAN_STREAM_DECODER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define CHSD_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m: check failed");
`define CHSD_ASSERT_R(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m: check failed");
`else
`define CHSD_ASSERT(label, clk, rst, prop)
`define CHSD_ASSERT_R(label, clk, prop)
`endif
`endif

// ----- hw/rtl/chsd_pkg.sv -----
// Package for the canonical Huffman stream decoder: constants and result type.
// No dependencies.
`timescale 1ns / 1ps
package chsd_pkg;
  localparam int MaxCodeLength = 63;
  localparam int AlphabetSize  = 256;
  localparam int LenCountDepth = 64;

  typedef struct packed {
    logic [7:0] symbol;
    logic       symbol_valid;
    logic       run_last;
    logic       stream_end;
    logic       code_error;
  } result_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } request_t;
endpackage

// ----- hw/rtl/chsd_stream_if.sv -----
// Valid/ready channel carrying a payload of type T.
// Depends on chsd_pkg only through the payload type handed in.
`timescale 1ns / 1ps
interface chsd_stream_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/chsd_core.sv -----
// Bit-serial decoding engine: symbol table and length-count memories,
// header parsing and canonical code matching. Depends on chsd_pkg and macros.
`timescale 1ns / 1ps
`include "canonical_huffman_stream_decoder_unit_macros.svh"
module chsd_core import chsd_pkg::*; #(
  parameter int MAX_CODE_LENGTH = MaxCodeLength
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  request_t in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output result_t  out_data
);
  localparam logic [2:0] PH_PAD = 3'd0, PH_COUNT = 3'd1, PH_HEADER = 3'd2,
    PH_PAYLOAD = 3'd3, PH_CLEAR = 3'd4;
  localparam logic [2:0] S_IDLE = 3'd0, S_READ = 3'd1, S_EVAL = 3'd2,
    S_SYM = 3'd3, S_EMIT = 3'd4, S_WRITE = 3'd5;

  logic [7:0] symbol_table [AlphabetSize];
  logic [8:0] length_counts [LenCountDepth];

  logic [2:0]  phase;
  logic [2:0]  state;
  logic [2:0]  pad_bits;
  logic [8:0]  symbol_count;
  logic [8:0]  entry_counter;
  logic [13:0] entry_shift;
  logic [3:0]  entry_bits;
  logic [63:0] code_acc;
  logic [63:0] first_code;
  logic [8:0]  rank_base;
  logic [5:0]  code_len;
  logic [8:0]  count0;
  logic [5:0]  clr_idx;

  logic [7:0] byte_q;
  logic [3:0] bit_idx;
  logic [3:0] nbits;

  logic [5:0] cnt_addr;
  logic [8:0] cnt_rd;
  logic [7:0] sym_addr;
  logic [7:0] sym_rd;
  logic [7:0] sym_sel;

  result_t    res;
  result_t    held;
  logic       res_pend;
  logic       end_pend;

  logic        cur_bit;
  logic [63:0] acc_new;
  logic [63:0] off;
  logic        hit;
  logic [13:0] shift_new;
  logic        single;
  logic        out_free;
  logic        out_load;

  assign single    = (symbol_count == 9'd1);
  assign cur_bit   = byte_q[3'd7 - bit_idx[2:0]];
  assign acc_new   = {code_acc[62:0], cur_bit};
  assign off       = code_acc - first_code;
  assign hit       = off < {55'd0, cnt_rd};
  assign shift_new = {entry_shift[12:0], cur_bit};
  assign in_ready  = (state == S_IDLE) && !out_valid && (phase != PH_CLEAR);
  assign out_free  = !out_valid || out_ready;
  assign out_load  = out_free && (((state == S_SYM) && res_pend) ||
                                  ((state == S_EMIT) && (res_pend || end_pend)));

  always_ff @(posedge clk) begin
    cnt_rd <= length_counts[cnt_addr];
    sym_rd <= symbol_table[sym_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_CLEAR; state <= S_IDLE; clr_idx <= '0;
      pad_bits <= '0; symbol_count <= '0; entry_counter <= '0; entry_shift <= '0;
      entry_bits <= '0; code_acc <= '0; first_code <= '0; rank_base <= '0;
      code_len <= '0; count0 <= '0; res_pend <= 1'b0; end_pend <= 1'b0;
      bit_idx <= '0; nbits <= '0; byte_q <= '0; sym_sel <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (phase == PH_CLEAR) begin
            length_counts[clr_idx] <= '0;
            clr_idx <= clr_idx + 6'd1;
            if (clr_idx == 6'(LenCountDepth - 1))
              phase <= (symbol_count == 9'd0) ? PH_PAD : PH_HEADER;
          end else if (in_valid && in_ready) begin
            byte_q <= in_data.data_byte;
            bit_idx <= '0;
            nbits <= in_data.final_byte ? (4'd8 - {1'b0, pad_bits}) : 4'd8;
            end_pend <= in_data.final_byte;
            if (phase == PH_PAD) begin
              pad_bits <= in_data.data_byte[2:0];
              phase <= PH_COUNT;
              state <= in_data.final_byte ? S_EMIT : S_IDLE;
            end else if (phase == PH_COUNT) begin
              symbol_count <= (in_data.data_byte == 8'd0) ? 9'd256
                                                           : {1'b0, in_data.data_byte};
              entry_counter <= '0; entry_shift <= '0; entry_bits <= '0;
              code_acc <= '0; first_code <= '0; rank_base <= '0; code_len <= '0;
              count0 <= '0;
              phase <= PH_CLEAR; clr_idx <= '0;
              state <= in_data.final_byte ? S_EMIT : S_IDLE;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          if (bit_idx == nbits) begin
            state <= S_EMIT;
          end else if (phase == PH_HEADER) begin
            entry_shift <= shift_new;
            entry_bits <= entry_bits + 4'd1;
            bit_idx <= bit_idx + 4'd1;
            if (entry_bits + 4'd1 == (single ? 4'd8 : 4'd14)) state <= S_WRITE;
          end else if (single) begin
            res <= '{symbol: 8'd0, symbol_valid: 1'b1, run_last: 1'b0,
                     stream_end: 1'b0, code_error: 1'b0};
            bit_idx <= bit_idx + 4'd1;
            state <= S_SYM;
          end else begin
            code_len <= code_len + 6'd1;
            code_acc <= acc_new;
            bit_idx <= bit_idx + 4'd1;
            state <= S_EVAL;
          end
        end
        S_WRITE: begin
          // cnt_rd holds length_counts[entry length]
          if (single) begin
            symbol_table[0] <= entry_shift[7:0];
          end else begin
            if (entry_shift[5:0] != 6'd0)
              symbol_table[8'(entry_counter - count0)] <= entry_shift[13:6];
            length_counts[entry_shift[5:0]] <= cnt_rd + 9'd1;
            if (entry_shift[5:0] == 6'd0) count0 <= count0 + 9'd1;
          end
          entry_shift <= '0; entry_bits <= '0;
          entry_counter <= entry_counter + 9'd1;
          if (entry_counter + 9'd1 == symbol_count) begin
            phase <= PH_PAYLOAD;
            code_acc <= '0; first_code <= '0; rank_base <= '0; code_len <= '0;
          end
          state <= S_READ;
        end
        S_EVAL: begin
          if (hit) begin
            state <= S_SYM;
            sym_sel <= 8'(rank_base + off[8:0]);
            res <= '{symbol: 8'd0, symbol_valid: 1'b1, run_last: 1'b0,
                     stream_end: 1'b0, code_error: 1'b0};
            code_acc <= '0; first_code <= '0; rank_base <= '0; code_len <= '0;
          end else if ({26'd0, code_len} >= 32'(MAX_CODE_LENGTH)) begin
            res <= '{symbol: 8'd0, symbol_valid: 1'b0, run_last: 1'b0,
                     stream_end: 1'b0, code_error: 1'b1};
            code_acc <= '0; first_code <= '0; rank_base <= '0; code_len <= '0;
            state <= S_SYM;
          end else begin
            rank_base <= rank_base + cnt_rd;
            first_code <= (first_code + {55'd0, cnt_rd}) << 1;
            state <= S_READ;
          end
        end
        S_SYM: begin
          // hold the newest result until the byte shows whether it is the last
          if (!res_pend || out_free) begin
            if (res_pend) out_data <= held;
            held <= '{symbol: res.symbol_valid ? sym_rd : 8'd0,
                      symbol_valid: res.symbol_valid, run_last: 1'b0,
                      stream_end: 1'b0, code_error: res.code_error};
            res_pend <= 1'b1;
            state <= S_READ;
          end
        end
        S_EMIT: begin
          if (res_pend) begin
            if (out_free) begin
              out_data <= '{symbol: held.symbol, symbol_valid: held.symbol_valid,
                            run_last: !end_pend, stream_end: 1'b0,
                            code_error: held.code_error};
              res_pend <= 1'b0;
              if (!end_pend) state <= S_IDLE;
            end
          end else if (!end_pend) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_data <= '{symbol: 8'd0, symbol_valid: 1'b0, run_last: 1'b1,
                          stream_end: 1'b1, code_error: 1'b0};
            end_pend <= 1'b0;
            pad_bits <= '0; symbol_count <= '0; entry_counter <= '0;
            entry_shift <= '0; entry_bits <= '0; count0 <= '0;
            code_acc <= '0; first_code <= '0; rank_base <= '0; code_len <= '0;
            phase <= PH_CLEAR; clr_idx <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // memory addresses: presented in the cycle before their read data is used
  always_comb begin
    cnt_addr = code_len + 6'd1;
    sym_addr = single ? 8'd0 : sym_sel;
    if (state == S_READ && phase == PH_HEADER) cnt_addr = shift_new[5:0];
    if (state == S_EVAL) sym_addr = 8'(rank_base + off[8:0]);
  end

  `CHSD_ASSERT(a_single_out_hold, clk, rst, (out_valid && !out_ready) |=> out_valid)
  `CHSD_ASSERT(a_idle_when_ready, clk, rst, in_ready |-> (state == S_IDLE))
  `CHSD_ASSERT(a_err_not_valid, clk, rst, (out_valid && out_data.code_error) |-> !out_data.symbol_valid)
endmodule

// ----- hw/rtl/canonical_huffman_stream_decoder_unit.sv -----
// Top level of the canonical Huffman stream decoder.
// Depends on chsd_pkg, chsd_stream_if, chsd_core and the macros header.
//   channel  dir  payload
//   in_ch    in   data_byte, final_byte
//   out_ch   out  symbol, symbol_valid, run_last, stream_end, code_error
// Pad and count bytes are handled in S_IDLE (S_EMIT if final). Other bytes are
// accepted in S_IDLE, header bits go through S_READ, entries S_WRITE, payload
// bits S_READ and S_EVAL, results S_SYM; S_READ closes the byte, S_EMIT sends
// the held result and any end marker. The length-count memory is cleared after
// reset, each count byte and each end marker; no request is taken meanwhile.
// A second result waits on a stalled output; a request waits for an empty output.
`timescale 1ns / 1ps
`include "canonical_huffman_stream_decoder_unit_macros.svh"
module canonical_huffman_stream_decoder_unit import chsd_pkg::*; #(
  parameter int MAX_CODE_LENGTH = MaxCodeLength
) (
  input logic        clk,
  input logic        rst,
  chsd_stream_if.sink   in_ch,
  chsd_stream_if.source out_ch
);
  chsd_core #(.MAX_CODE_LENGTH(MAX_CODE_LENGTH)) u_core (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
  );

  `CHSD_ASSERT(a_out_stable, clk, rst, (out_ch.valid && !out_ch.ready) |=> $stable(out_ch.data))
  `CHSD_ASSERT(a_end_last, clk, rst, (out_ch.valid && out_ch.data.stream_end) |-> out_ch.data.run_last)
  `CHSD_ASSERT_R(a_reset_quiet, clk, $past(rst) |-> !out_ch.valid)
endmodule

// ----- test/tb.sv -----
// Testbench for canonical_huffman_stream_decoder_unit: streams of bytes with random stalls.
// A built-in predictor of the stream decoder supplies the expected symbols and end markers.
// Depends on chsd_pkg, chsd_stream_if and the decoder RTL.
`timescale 1ns / 1ps
module tb;
  import chsd_pkg::*;

  typedef enum logic [1:0] {PH_PAD, PH_COUNT, PH_HEADER, PH_PAYLOAD} phase_e;

  logic clk;
  logic rst;

  chsd_stream_if #(.T(request_t)) in_ch (clk);
  chsd_stream_if #(.T(result_t))  out_ch (clk);

  canonical_huffman_stream_decoder_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // decoder state as predicted
  phase_e      phase;
  int          pad_n, nsym, ent_cnt, ent_bits, rank_base, code_len;
  logic [13:0] ent_shift;
  logic [7:0]  sym_mem [256];
  int          len_cnt [64];
  logic [63:0] code_acc, first_code;

  result_t     expected_q[$];
  int          n_errors, n_requests, n_results, n_streams, n_symbols, n_code_errors;
  int          hold_req;
  bit          no_idle;

  logic [7:0]  strm[$];
  bit          bitq[$];
  int          hdr_len[$];
  logic [7:0]  hdr_sym[$];

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic void push_result(logic [7:0] s, logic v, logic e, logic er);
    result_t r;
    r.symbol = s;
    r.symbol_valid = v;
    r.run_last = 1'b0;
    r.stream_end = e;
    r.code_error = er;
    expected_q.push_back(r);
  endfunction

  function automatic void clear_code();
    code_acc = '0;
    first_code = '0;
    rank_base = 0;
    code_len = 0;
  endfunction

  function automatic void clear_stream();
    phase = PH_PAD;
    pad_n = 0;
    nsym = 0;
    ent_cnt = 0;
    ent_shift = '0;
    ent_bits = 0;
    for (int i = 0; i < 64; i++) len_cnt[i] = 0;
    clear_code();
  endfunction

  function automatic void header_bit(logic b);
    int width;
    int len;
    logic [7:0] s;
    width = (nsym == 1) ? 8 : 14;
    ent_shift = {ent_shift[12:0], b};
    ent_bits++;
    if (ent_bits < width) return;
    s = 8'(ent_shift >> (width - 8));
    if (nsym == 1) begin
      sym_mem[0] = s;
    end else begin
      len = int'(ent_shift[5:0]);
      if (len != 0) sym_mem[(ent_cnt - len_cnt[0]) & 255] = s;
      len_cnt[len] = (len_cnt[len] + 1) & 511;
    end
    ent_shift = '0;
    ent_bits = 0;
    ent_cnt = (ent_cnt + 1) & 511;
    if (ent_cnt == nsym) begin
      phase = PH_PAYLOAD;
      clear_code();
    end
  endfunction

  function automatic void payload_bit(logic b);
    logic [63:0] cnt, off;
    if (nsym == 1) begin
      push_result(sym_mem[0], 1'b1, 1'b0, 1'b0);
      return;
    end
    code_len = (code_len + 1) & 63;
    code_acc = {code_acc[62:0], b};
    cnt = 64'(len_cnt[code_len]);
    off = code_acc - first_code;
    if (off < cnt) begin
      push_result(sym_mem[(rank_base + int'(off[8:0])) & 255], 1'b1, 1'b0, 1'b0);
      clear_code();
      return;
    end
    rank_base = (rank_base + int'(cnt)) & 511;
    first_code = (first_code + cnt) << 1;
    if (code_len >= MaxCodeLength) begin
      push_result(8'h00, 1'b0, 1'b0, 1'b1);
      clear_code();
    end
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic fin);
    int n_prior;
    int nbits;
    result_t r;
    n_prior = expected_q.size();
    if (phase == PH_PAD) begin
      pad_n = int'(b[2:0]);
      phase = PH_COUNT;
    end else if (phase == PH_COUNT) begin
      nsym = (b == 8'h00) ? 256 : int'(b);
      ent_cnt = 0;
      ent_shift = '0;
      ent_bits = 0;
      for (int i = 0; i < 64; i++) len_cnt[i] = 0;
      clear_code();
      phase = PH_HEADER;
    end else begin
      nbits = fin ? 8 - pad_n : 8;
      for (int i = 0; i < nbits; i++) begin
        if (phase == PH_HEADER) header_bit(b[7-i]);
        else payload_bit(b[7-i]);
      end
    end
    if (fin) begin
      push_result(8'h00, 1'b0, 1'b1, 1'b0);
      clear_stream();
    end
    if (expected_q.size() > n_prior) begin
      r = expected_q.pop_back();
      r.run_last = 1'b1;
      expected_q.push_back(r);
    end
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    n_errors++;
  endtask

  task automatic check_result(result_t got);
    result_t want;
    n_results++;
    if (expected_q.size() == 0) begin
      report("unexpected result", int'(got), 0);
      return;
    end
    want = expected_q.pop_front();
    if (got.symbol !== want.symbol)
      report("symbol", int'(got.symbol), int'(want.symbol));
    if (got.symbol_valid !== want.symbol_valid)
      report("symbol_valid", int'(got.symbol_valid), int'(want.symbol_valid));
    if (got.run_last !== want.run_last)
      report("run_last", int'(got.run_last), int'(want.run_last));
    if (got.stream_end !== want.stream_end)
      report("stream_end", int'(got.stream_end), int'(want.stream_end));
    if (got.code_error !== want.code_error)
      report("code_error", int'(got.code_error), int'(want.code_error));
    if (want.symbol_valid) n_symbols++;
    if (want.code_error) n_code_errors++;
    if (want.stream_end) n_streams++;
  endtask

  // receiver
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_req > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_req) @(posedge clk);
        hold_req = 0;
      end
      stall = no_idle ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      check_result(out_ch.data);
    end
  end

  task automatic send_byte(logic [7:0] b, logic fin);
    int gap;
    request_t r;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    r.data_byte = b;
    r.final_byte = fin;
    in_ch.valid <= 1'b1;
    in_ch.data <= r;
    do @(posedge clk); while (!in_ch.ready);
    predict_byte(b, fin);
    n_requests++;
  endtask

  // send strm, ending it after cut bytes when cut is below its length
  task automatic send_stream(int cut);
    int last;
    last = (cut < strm.size()) ? cut - 1 : strm.size() - 1;
    for (int i = 0; i <= last; i++) send_byte(strm[i], i == last);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic push_bits(logic [15:0] v, int w);
    for (int i = w - 1; i >= 0; i--) bitq.push_back(v[i]);
  endtask

  // pack the header in hdr_sym/hdr_len and pay random payload bytes into strm
  task automatic build_stream(int pay);
    int n;
    int padn;
    logic [7:0] b;
    n = hdr_sym.size();
    bitq.delete();
    strm.delete();
    for (int i = 0; i < n; i++) begin
      push_bits(16'(hdr_sym[i]), 8);
      if (n != 1) push_bits(16'(hdr_len[i]), 6);
    end
    for (int i = 0; i < pay * 8; i++) bitq.push_back(1'($urandom_range(0, 1)));
    padn = (8 - bitq.size() % 8) % 8;
    for (int i = 0; i < padn; i++) bitq.push_back(1'($urandom_range(0, 1)));
    strm.push_back({5'($urandom_range(0, 31)), 3'(padn)});
    strm.push_back(8'(n));
    for (int i = 0; i < bitq.size(); i += 8) begin
      for (int j = 0; j < 8; j++) b[7-j] = bitq[i+j];
      strm.push_back(b);
    end
  endtask

  // complete prefix code of n symbols by splitting leaves no deeper than maxd
  task automatic pick_code(int n, int maxd, int zeros);
    int i;
    int l;
    hdr_len.delete();
    hdr_sym.delete();
    if (n == 1) begin
      hdr_len.push_back(0);
    end else begin
      hdr_len.push_back(1);
      hdr_len.push_back(1);
      while (hdr_len.size() < n) begin
        i = $urandom_range(0, hdr_len.size() - 1);
        l = hdr_len[i];
        if (l < maxd) begin
          hdr_len[i] = l + 1;
          hdr_len.push_back(l + 1);
        end
      end
      hdr_len.sort();
      for (int k = 0; k < zeros; k++) hdr_len.push_front(0);
    end
    foreach (hdr_len[k]) hdr_sym.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic test_early_end();
    strm = '{8'hff, 8'h03, 8'h12, 8'h34};
    send_stream(1);
    send_stream(2);
    send_stream(3);
    drain();
  endtask

  task automatic test_single_symbol();
    pick_code(1, 1, 0);
    hdr_sym[0] = 8'hff;
    build_stream(2);
    strm[2] = 8'h00;
    send_stream(99);
    drain();
  endtask

  task automatic test_zero_and_unordered();
    hdr_len = '{0, 2, 1, 0, 2};
    hdr_sym = '{8'h00, 8'h80, 8'h7f, 8'h11, 8'hff};
    build_stream(3);
    strm[strm.size() - 1] = 8'h00;
    strm[strm.size() - 2] = 8'hff;
    strm[0] = 8'h07;
    strm.push_back(8'h00);
    send_stream(99);
    drain();
  endtask

  task automatic test_code_error();
    hdr_len = '{1, 63};
    hdr_sym = '{8'h5a, 8'ha5};
    build_stream(0);
    repeat (9) strm.push_back(8'hff);
    strm[0] = 8'h00;
    send_stream(99);
    drain();
  endtask

  // 64 six-bit codes, then the same bytes read with a count byte of 0 (256 symbols)
  task automatic test_wide_alphabet();
    hdr_len.delete();
    hdr_sym.delete();
    for (int i = 0; i < 64; i++) begin
      hdr_len.push_back(6);
      hdr_sym.push_back(8'(255 - i));
    end
    build_stream(4);
    send_stream(99);
    drain();
    strm[1] = 8'h00;
    send_stream(99);
    drain();
  endtask

  task automatic test_backpressure();
    pick_code(6, 4, 0);
    build_stream(12);
    no_idle = 1'b1;
    hold_req = 400;
    send_stream(99);
    drain();
    no_idle = 1'b0;
  endtask

  task automatic test_random();
    int kind;
    int n;
    while (n_requests < 450) begin
      kind = $urandom_range(0, 9);
      no_idle = ($urandom_range(0, 5) == 0);
      if (kind == 0) begin
        strm.delete();
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) strm.push_back(8'($urandom_range(0, 255)));
        send_stream(99);
      end else begin
        n = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 12);
        pick_code(n, ($urandom_range(0, 7) == 0) ? 62 : 12,
                  ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0);
        build_stream($urandom_range(1, 10));
        send_stream((kind == 1) ? $urandom_range(1, strm.size()) : 99);
      end
      if ($urandom_range(0, 9) == 0) drain();
    end
    no_idle = 1'b0;
    drain();
  endtask

  initial begin
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    hold_req = 0;
    no_idle = 1'b0;
    n_errors = 0;
    n_requests = 0;
    n_results = 0;
    n_streams = 0;
    n_symbols = 0;
    n_code_errors = 0;
    for (int i = 0; i < 256; i++) sym_mem[i] = '0;
    clear_stream();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    repeat (100) @(posedge clk);
    test_early_end();
    test_single_symbol();
    test_zero_and_unordered();
    test_code_error();
    test_wide_alphabet();
    test_backpressure();
    test_random();
    $display("covered %0d requests, %0d streams ended, %0d results checked",
             n_requests, n_streams, n_results);
    $display("decoded %0d symbols and %0d over-long codes", n_symbols, n_code_errors);
    if (n_errors == 0) begin
      $display("PASS canonical_huffman_stream_decoder_unit");
    end else begin
      $display("FAIL canonical_huffman_stream_decoder_unit");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAIL canonical_huffman_stream_decoder_unit");
    $finish;
  end
endmodule
